// File: hw/rtl/vpdh_pkg.sv
// Shared types and constants for the voxel point density histogram.
`timescale 1ns / 1ps

package vpdh_pkg;

  // Fixed field widths
  localparam int COORD_W     = 32;
  localparam int IDX_W       = 15;
  localparam int OUT_COUNT_W = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int STORE_DEPTH = 32768;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Z    = 3'd5;

  localparam logic [COORD_W-1:0] INV_SPACING_RESET = 32'h0001_0000;

  // Item kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Axis being binned by the shared multiplier
  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  // Input beat
  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [IDX_W-1:0]          read_bin;
  } vpdh_in_t;

  // Result beat
  typedef struct packed {
    logic [IDX_W-1:0]       bin_index;
    logic [OUT_COUNT_W-1:0] bin_count;
  } vpdh_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic  clr_wr;
    logic  load;
    logic  off_en;
    logic  mul_en;
    logic  acc_en;
    logic  rd_en;
    logic  wr_en;
    axis_t axis;
  } vpdh_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;
  } vpdh_sts_t;

endpackage

// File: hw/rtl/vpdh_ctrl.sv
// Sequencing state machine for the voxel histogram.
`timescale 1ns / 1ps

module vpdh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_kind,
  input  vpdh_pkg::vpdh_sts_t sts,
  output vpdh_pkg::vpdh_cmd_t cmd,
  output logic                busy
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_OFF   = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_ACC   = 7'b0010000,
    ST_RD    = 7'b0100000,
    ST_WR    = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  vpdh_pkg::axis_t axis_r, axis_nxt;

  // State and axis registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      axis_r  <= vpdh_pkg::AX_Z;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          axis_nxt  = vpdh_pkg::AX_Z;
          state_nxt = (in_kind == vpdh_pkg::KIND_READ) ? ST_RD : ST_OFF;
        end
      end
      ST_OFF: begin
        cmd.off_en = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_en = 1'b1;
        // walk z, then y, then x (Horner order for the linear index)
        case (axis_r)
          vpdh_pkg::AX_Z: begin
            axis_nxt  = vpdh_pkg::AX_Y;
            state_nxt = ST_OFF;
          end
          vpdh_pkg::AX_Y: begin
            axis_nxt  = vpdh_pkg::AX_X;
            state_nxt = ST_OFF;
          end
          default: state_nxt = ST_RD;
        endcase
      end
      ST_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        cmd.wr_en = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// File: hw/rtl/vpdh_datapath.sv
// Datapath: config registers, binning arithmetic, count store and result register.
`timescale 1ns / 1ps

module vpdh_datapath #(
  parameter int GRID_X     = 32,
  parameter int GRID_Y     = 32,
  parameter int GRID_Z     = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  vpdh_pkg::vpdh_cmd_t                    cmd,
  output vpdh_pkg::vpdh_sts_t                    sts,
  input  vpdh_pkg::vpdh_in_t                     in_data,
  input  logic                                   cfg_we,
  input  logic [vpdh_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [vpdh_pkg::COORD_W-1:0]           cfg_data,
  output logic                                   out_valid,
  output vpdh_pkg::vpdh_out_t                    out_data
);

  localparam int CW = vpdh_pkg::COORD_W;
  localparam int IW = vpdh_pkg::IDX_W;
  localparam int OW = vpdh_pkg::OUT_COUNT_W;

  // Largest cell per axis and the Horner multipliers
  localparam logic [CW-1:0] MAX_X = CW'(GRID_X - 1);
  localparam logic [CW-1:0] MAX_Y = CW'(GRID_Y - 1);
  localparam logic [CW-1:0] MAX_Z = CW'(GRID_Z - 1);
  localparam logic [IW-1:0] MUL_X = IW'(GRID_X);
  localparam logic [IW-1:0] MUL_Y = IW'(GRID_Y);

  logic [CW-1:0] org_x_r, org_y_r, org_z_r;
  logic [CW-1:0] inv_x_r, inv_y_r, inv_z_r;

  logic          kind_r;
  logic [CW-1:0] px_r, py_r, pz_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW:0]   off_r, off_nxt;
  logic          neg_r;
  logic [2*CW-1:0] prod_r, prod_nxt;
  logic [IW-1:0] clr_addr_r;
  logic [COUNT_BITS-1:0] rdata_r;
  logic [COUNT_BITS-1:0] new_cnt, wdata, rep_cnt;
  logic [OW-1:0] out_cnt;
  logic          out_valid_r;
  vpdh_pkg::vpdh_out_t out_data_r;

  logic [COUNT_BITS-1:0] mem [vpdh_pkg::STORE_DEPTH];

  logic [CW-1:0] pt_sel, org_sel, inv_sel, max_sel, cell_int, cell_sat;
  logic [IW-1:0] mul_sel;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
      inv_x_r <= vpdh_pkg::INV_SPACING_RESET;
      inv_y_r <= vpdh_pkg::INV_SPACING_RESET;
      inv_z_r <= vpdh_pkg::INV_SPACING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        vpdh_pkg::REG_ORIGIN_X: org_x_r <= cfg_data;
        vpdh_pkg::REG_ORIGIN_Y: org_y_r <= cfg_data;
        vpdh_pkg::REG_ORIGIN_Z: org_z_r <= cfg_data;
        vpdh_pkg::REG_INV_X:    inv_x_r <= cfg_data;
        vpdh_pkg::REG_INV_Y:    inv_y_r <= cfg_data;
        vpdh_pkg::REG_INV_Z:    inv_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-axis operand selection
  always_comb begin
    case (cmd.axis)
      vpdh_pkg::AX_X: begin
        pt_sel = px_r; org_sel = org_x_r; inv_sel = inv_x_r;
        max_sel = MAX_X; mul_sel = MUL_X;
      end
      vpdh_pkg::AX_Y: begin
        pt_sel = py_r; org_sel = org_y_r; inv_sel = inv_y_r;
        max_sel = MAX_Y; mul_sel = MUL_Y;
      end
      default: begin
        // z comes first, index is still zero
        pt_sel = pz_r; org_sel = org_z_r; inv_sel = inv_z_r;
        max_sel = MAX_Z; mul_sel = '0;
      end
    endcase
  end

  // Exact signed offset, then 32x32 product of a non-negative offset
  assign off_nxt  = {pt_sel[CW-1], pt_sel} - {org_sel[CW-1], org_sel};
  assign prod_nxt = off_r[CW-1:0] * inv_sel;

  // Truncate to the integer cell, clamp, fold into the linear index
  assign cell_int = prod_r[2*CW-1:CW];
  assign cell_sat = neg_r ? '0 : ((cell_int > max_sel) ? max_sel : cell_int);
  assign idx_nxt  = IW'(idx_r * mul_sel) + cell_sat[IW-1:0];

  // Item registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_data.kind;
      px_r   <= in_data.point_x;
      py_r   <= in_data.point_y;
      pz_r   <= in_data.point_z;
      idx_r  <= (in_data.kind == vpdh_pkg::KIND_READ) ? in_data.read_bin : '0;
    end else if (cmd.acc_en) begin
      idx_r  <= idx_nxt;
    end
    if (cmd.off_en) off_r <= off_nxt;
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
      neg_r  <= off_r[CW];
    end
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign sts.clr_done = (clr_addr_r == {IW{1'b1}});

  // Count update: saturating increment, or clear on read
  assign new_cnt = (rdata_r == {COUNT_BITS{1'b1}}) ? rdata_r : rdata_r + 1'b1;
  assign wdata   = (kind_r == vpdh_pkg::KIND_READ) ? '0 : new_cnt;
  assign rep_cnt = (kind_r == vpdh_pkg::KIND_READ) ? rdata_r : new_cnt;

  // Count store, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.wr_en) begin
      mem[idx_r] <= wdata;
    end
    if (cmd.rd_en) rdata_r <= mem[idx_r];
  end

  // Fit the stored count to the output field
  generate
    if (COUNT_BITS > OW) begin : g_out_sat
      assign out_cnt = (rep_cnt > COUNT_BITS'({OW{1'b1}})) ? {OW{1'b1}} : rep_cnt[OW-1:0];
    end else begin : g_out_ext
      assign out_cnt = OW'(rep_cnt);
    end
  endgenerate

  // Result register, strobe lasts one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.wr_en;
    end
    if (cmd.wr_en) begin
      out_data_r.bin_index <= idx_r;
      out_data_r.bin_count <= out_cnt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/voxel_point_density_histogram.sv
// Top level of the voxel point density histogram.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | in        | start, busy            | in_data  (kind, point xyz, bin)
//  out     | out       | out_valid (one cycle)  | out_data (bin_index, bin_count)
//  cfg     | in        | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// For an add beat, one shared 32x32 multiplier bins z, y and x in turn (offset,
// product, clamp and index fold per axis), then the count store is read and written
// back. A read beat is a store read, a write-back of zero and a result strobe.
// No new beat is accepted until the last one is through. After reset a clearing
// pass zeroes all 32768 store entries, one entry a cycle, with busy high. The
// result strobe is never held off; cfg_ready is always high.
`timescale 1ns / 1ps

module voxel_point_density_histogram #(
  parameter int GRID_X     = 32,
  parameter int GRID_Y     = 32,
  parameter int GRID_Z     = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  vpdh_pkg::vpdh_in_t             in_data,
  output logic                           out_valid,
  output vpdh_pkg::vpdh_out_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vpdh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vpdh_pkg::COORD_W-1:0]   cfg_data
);

  vpdh_pkg::vpdh_cmd_t cmd;
  vpdh_pkg::vpdh_sts_t sts;

  assign cfg_ready = 1'b1;

  vpdh_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_data.kind),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  vpdh_datapath #(
    .GRID_X     (GRID_X),
    .GRID_Y     (GRID_Y),
    .GRID_Z     (GRID_Z),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // An accepted beat keeps the block busy until its result is out
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a beat");

  // Results come out one at a time, when the block has gone idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // The clearing pass never overlaps item work on the store
  a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> (!cmd.wr_en && !cmd.rd_en && !cmd.load))
    else $error("store access during clearing pass");

endmodule
